@@ rtl/lir_pkg.sv @@
// ----------------------------------------------------------------------------
// lir_pkg: shared constants for the linear interpolation rate changer
// Default widths of the sample, index and position fields, and the fixed
// width of the step ratio register.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int DEF_INDEX_BITS  = 20;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 16;

    // Step ratio register, unsigned with FRAC_BITS fraction bits
    localparam int RATIO_BITS = 24;

endpackage

@@ rtl/lir_in_if.sv @@
// ----------------------------------------------------------------------------
// lir_in_if: input sample channel
// Valid/ready channel carrying one audio sample and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface lir_in_if
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          last_in_frame;

    modport source (output valid, output in_sample, output last_in_frame, input ready);
    modport sink   (input valid, input in_sample, input last_in_frame, output ready);
endinterface

@@ rtl/lir_out_if.sv @@
// ----------------------------------------------------------------------------
// lir_out_if: result channel
// Valid/ready channel carrying one result per input transaction.
// ----------------------------------------------------------------------------
interface lir_out_if
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          out_valid;
    logic                          frame_end;
    logic        [INDEX_BITS-1:0]  produced_count;

    modport source (output valid, output out_sample, output out_valid, output frame_end,
                    output produced_count, input ready);
    modport sink   (input valid, input out_sample, input out_valid, input frame_end,
                    input produced_count, output ready);
endinterface

@@ rtl/lir_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lir_cfg_if: configuration write channel
// Valid/ready channel carrying the step ratio register value.
// ----------------------------------------------------------------------------
interface lir_cfg_if
    import lir_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [RATIO_BITS-1:0] rate_ratio;

    modport source (output valid, output rate_ratio, input ready);
    modport sink   (input valid, input rate_ratio, output ready);
endinterface

@@ rtl/lir_interp.sv @@
// ----------------------------------------------------------------------------
// lir_interp: two-point linear interpolator
// lo + (hi - lo) * frac / 2^FRAC_BITS, rounded half up. One multiplier.
// ----------------------------------------------------------------------------
module lir_interp
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic signed [SAMPLE_BITS-1:0] lo_sample,
    input  logic signed [SAMPLE_BITS-1:0] hi_sample,
    input  logic        [FRAC_BITS-1:0]   frac,
    output logic signed [SAMPLE_BITS-1:0] value
);

    localparam int ACC_BITS = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) <<< (FRAC_BITS - 1);

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [ACC_BITS-1:0]    prod;
    logic signed [ACC_BITS-1:0]    base;
    logic signed [ACC_BITS-1:0]    acc;
    logic signed [ACC_BITS-1:0]    shifted;

    always_comb
    begin
        diff    = (SAMPLE_BITS + 1)'(hi_sample) - (SAMPLE_BITS + 1)'(lo_sample);
        frac_s  = $signed({1'b0, frac});
        prod    = diff * frac_s;
        base    = ACC_BITS'(lo_sample) <<< FRAC_BITS;
        acc     = base + prod + HALF;
        // result always lies between lo and hi, so truncation is safe
        shifted = acc >>> FRAC_BITS;
        value   = shifted[SAMPLE_BITS-1:0];
    end

endmodule

@@ rtl/linear_interp_rate_changer.sv @@
// ----------------------------------------------------------------------------
// linear_interp_rate_changer: downward audio resampler, linear interpolation
// Output k of a frame sits at input position k * ratio (ratio >= 1); each
// output is the interpolation of the two input samples around it.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one input sample per transaction, last_in_frame
//             marks the final sample of a frame.
//   results : source channel, exactly one result per input transaction.
//             out_valid tells whether a resampled sample came out; output 0
//             of every frame is zero. produced_count is the running count
//             for the frame and is final on the result with frame_end set.
//   cfg     : write channel for the step ratio (unsigned, FRAC_BITS fraction
//             bits). Always ready. Write only while the block is idle.
//             Ratios below one are treated as one.
// The result of a sample is written to the output register at the edge that
// accepts it. Throughput is one transaction per cycle while the receiver does
// not stall, set by the single output register; frame state updates on every
// acceptance. When the receiver stalls, the output register holds its result
// and samples.ready is high only if that register is empty or drains.
// Reset clears the frame state and sets the ratio to one; no result pending.
// ----------------------------------------------------------------------------
module linear_interp_rate_changer
    import lir_pkg::*;
#(
    parameter int INDEX_BITS  = DEF_INDEX_BITS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    lir_in_if.sink       samples,
    lir_out_if.source    results,
    lir_cfg_if.sink      cfg
);

    // Position: INDEX_BITS integer part, FRAC_BITS fraction
    localparam int POS_BITS  = INDEX_BITS + FRAC_BITS;
    // Step must hold both the register and the value one
    localparam int STEP_BITS = (RATIO_BITS > FRAC_BITS + 1) ? RATIO_BITS : FRAC_BITS + 1;
    localparam int SUM_BITS  = ((POS_BITS > STEP_BITS) ? POS_BITS : STEP_BITS) + 1;

    localparam logic [STEP_BITS-1:0]  ONE_STEP    = STEP_BITS'(1) << FRAC_BITS;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(64'd1 << FRAC_BITS);
    localparam logic [POS_BITS-1:0]   POS_MAX     = '1;
    localparam logic [INDEX_BITS-1:0] IDX_MAX     = '1;

    // Configuration
    logic [RATIO_BITS-1:0] rate_ratio_reg;

    // Frame state
    logic [INDEX_BITS-1:0]         sample_index_reg, sample_index_next;
    logic [POS_BITS-1:0]           next_position_reg, next_position_next;
    logic signed [SAMPLE_BITS-1:0] previous_sample_reg, previous_sample_next;
    logic [INDEX_BITS-1:0]         output_count_reg, output_count_next;

    // Output register
    logic                          res_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          frame_end_reg;

    logic                          accept;
    logic [STEP_BITS-1:0]          ratio_ext;
    logic [STEP_BITS-1:0]          step;
    logic                          first;
    logic [INDEX_BITS-1:0]         lo_index;
    logic                          hit;
    logic [SUM_BITS-1:0]           pos_wide;
    logic [POS_BITS-1:0]           pos_sat;
    logic signed [SAMPLE_BITS-1:0] interp_value;

    // Handshakes: a result may be pending as long as it drains this cycle
    assign samples.ready = !res_valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    lir_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .lo_sample (previous_sample_reg),
        .hi_sample (samples.in_sample),
        .frac      (next_position_reg[FRAC_BITS-1:0]),
        .value     (interp_value)
    );

    always_comb
    begin
        ratio_ext = STEP_BITS'(rate_ratio_reg);
        step      = (ratio_ext < ONE_STEP) ? ONE_STEP : ratio_ext;

        first    = (sample_index_reg == '0);
        lo_index = next_position_reg[POS_BITS-1:FRAC_BITS];
        // the upper neighbor is the current sample: both neighbors exist
        hit      = !first && (lo_index < sample_index_reg);

        // First sample: output 0 lands at zero, next one a ratio further
        if (first)
            pos_wide = SUM_BITS'(step);
        else
            pos_wide = SUM_BITS'(next_position_reg) + SUM_BITS'(step);
        pos_sat = (pos_wide > SUM_BITS'(POS_MAX)) ? POS_MAX : pos_wide[POS_BITS-1:0];

        out_valid_next  = first || hit;
        out_sample_next = hit ? interp_value : '0;

        output_count_next = output_count_reg;
        if (out_valid_next && output_count_reg != IDX_MAX)
            output_count_next = output_count_reg + 1'b1;

        next_position_next = out_valid_next ? pos_sat : next_position_reg;
        sample_index_next  = (sample_index_reg == IDX_MAX) ? sample_index_reg
                                                           : sample_index_reg + 1'b1;
        previous_sample_next = samples.in_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_ratio_reg <= RATIO_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            rate_ratio_reg <= cfg.rate_ratio;
        end
    end

    // Frame state; cleared after the frame's last sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg    <= '0;
            next_position_reg   <= '0;
            previous_sample_reg <= '0;
            output_count_reg    <= '0;
        end
        else if (accept)
        begin
            if (samples.last_in_frame)
            begin
                sample_index_reg    <= '0;
                next_position_reg   <= '0;
                previous_sample_reg <= '0;
                output_count_reg    <= '0;
            end
            else
            begin
                sample_index_reg    <= sample_index_next;
                next_position_reg   <= next_position_next;
                previous_sample_reg <= previous_sample_next;
                output_count_reg    <= output_count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (results.ready)
            res_valid_reg <= 1'b0;
    end

    // Result payload, no reset needed
    logic [INDEX_BITS-1:0] produced_count_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_sample_reg     <= out_sample_next;
            out_valid_reg      <= out_valid_next;
            frame_end_reg      <= samples.last_in_frame;
            produced_count_reg <= output_count_next;
        end
    end

    assign results.valid          = res_valid_reg;
    assign results.out_sample     = out_sample_reg;
    assign results.out_valid      = out_valid_reg;
    assign results.frame_end      = frame_end_reg;
    assign results.produced_count = produced_count_reg;

endmodule

@@ verif/linear_interp_rate_changer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_interp_rate_changer_test: self-checking bench for the rate changer
// Drives frames of audio samples with random gaps and random result stalls,
// rewrites the step ratio between phases, and checks every result transaction
// against a cycle-free model of the interpolator kept in this module.
// ----------------------------------------------------------------------------
module linear_interp_rate_changer_test;
    import lir_pkg::*;

    localparam int IB       = DEF_INDEX_BITS;
    localparam int SB       = DEF_SAMPLE_BITS;
    localparam int FB       = DEF_FRAC_BITS;
    localparam int POS_BITS = IB + FB;

    localparam logic [RATIO_BITS-1:0] RATIO_UNITY = RATIO_BITS'(1) << FB;
    localparam logic [63:0]           POS_LIMIT   = (64'd1 << POS_BITS) - 64'd1;
    localparam logic [IB-1:0]         IDX_LIMIT   = '1;
    localparam logic [SB-1:0]         SIGN_FLIP   = SB'(1) << (SB - 1);

    localparam int RANDOM_ITEMS = 1000;
    localparam int SETTLE_CYC   = 4;    // result latency plus margin
    localparam int WDOG_LIMIT   = 400;  // idle cycles before giving up
    localparam int MAX_REPORTS  = 10;

    // One result transaction, as the block reports it
    typedef struct packed {
        logic signed [SB-1:0] value;
        logic                 produced;
        logic                 frame_end;
        logic [IB-1:0]        count;
    } lir_result_t;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    // Directed row: either a ratio write or one sample; typed rows carry the
    // expected result inline, the rest are left to the interpolation model.
    typedef struct packed {
        row_kind_t             kind;
        logic [RATIO_BITS-1:0] ratio;
        logic signed [SB-1:0]  smp;
        logic                  last;
        logic                  typed;
        lir_result_t           want;
    } dir_row_t;

    typedef enum int {
        RATIO_ZERO, RATIO_BELOW_ONE, RATIO_ONE, RATIO_MAX,
        RATIO_SMALL, RATIO_HALF_STEP, RATIO_ANY
    } ratio_kind_t;

    localparam lir_result_t NO_RES = '0;

    localparam dir_row_t DIR_TAB [24] = '{
        // ratio one after reset: output 0 is zero, then each output is the
        // lower neighbor since the fraction is always zero
        '{ROW_SAMPLE, 24'h0,  16'sd32767, 1'b0, 1'b1, '{16'sd0,      1'b1, 1'b0, 20'd1}},
        '{ROW_SAMPLE, 24'h0, -16'sd32768, 1'b0, 1'b1, '{16'sd0,      1'b0, 1'b0, 20'd1}},
        '{ROW_SAMPLE, 24'h0,  16'sd32767, 1'b0, 1'b1, '{-16'sd32768, 1'b1, 1'b0, 20'd2}},
        '{ROW_SAMPLE, 24'h0,  16'sd0,     1'b1, 1'b1, '{16'sd32767,  1'b1, 1'b1, 20'd3}},
        // single-sample frame
        '{ROW_SAMPLE, 24'h0,  16'sd1234,  1'b1, 1'b1, '{16'sd0,      1'b1, 1'b1, 20'd1}},
        // ratio 1.5: half-way points, rounding ties go up
        '{ROW_WRITE,  24'h018000, 16'sd0, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0, -16'sd5,     1'b0, 1'b1, '{16'sd0,      1'b1, 1'b0, 20'd1}},
        '{ROW_SAMPLE, 24'h0,  16'sd0,     1'b0, 1'b1, '{16'sd0,      1'b0, 1'b0, 20'd1}},
        '{ROW_SAMPLE, 24'h0,  16'sd1,     1'b0, 1'b1, '{16'sd1,      1'b1, 1'b0, 20'd2}},
        '{ROW_SAMPLE, 24'h0, -16'sd1,     1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0,  16'sd0,     1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0, -16'sd1,     1'b1, 1'b0, NO_RES},
        // zero ratio behaves as one
        '{ROW_WRITE,  24'h000000, 16'sd0, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0,  16'sd100,   1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0,  16'sd200,   1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0, -16'sd300,   1'b1, 1'b0, NO_RES},
        // just below one, also clamped to one
        '{ROW_WRITE,  24'h00FFFF, 16'sd0, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0, -16'sd32768, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0,  16'sd32767, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0,  16'sd32767, 1'b1, 1'b0, NO_RES},
        // largest ratio: nothing past output 0 in a short frame
        '{ROW_WRITE,  24'hFFFFFF, 16'sd0, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 24'h0,  16'sd32767, 1'b0, 1'b1, '{16'sd0,      1'b1, 1'b0, 20'd1}},
        '{ROW_SAMPLE, 24'h0, -16'sd32768, 1'b1, 1'b1, '{16'sd0,      1'b0, 1'b1, 20'd1}},
        '{ROW_WRITE,  24'h010000, 16'sd0, 1'b0, 1'b0, NO_RES}
    };

    logic clk;
    logic rst_n;

    lir_in_if  smp_ch ();
    lir_out_if res_ch ();
    lir_cfg_if cfg_ch ();

    linear_interp_rate_changer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // Interpolation model state: mirrors the block's register and frame
    // state, advanced once per accepted sample transaction.
    // ------------------------------------------------------------------------
    logic [RATIO_BITS-1:0] step_ratio  = RATIO_UNITY;
    logic [IB-1:0]         frm_index   = '0;
    logic [POS_BITS-1:0]   frm_pos     = '0;
    logic [SB-1:0]         frm_prev    = '0;
    logic [IB-1:0]         frm_count   = '0;

    lir_result_t expected_results [$];

    int  mismatches    = 0;
    int  idle_cycles   = 0;
    bit  src_gaps_on   = 1'b1;
    bit  snk_stalls_on = 1'b1;

    // Linear interpolation in offset binary, rounded to nearest, ties up.
    function automatic logic [SB-1:0] interp_q15(logic [SB-1:0] lo, logic [SB-1:0] hi,
                                                 logic [FB-1:0] frac);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] f;
        logic [63:0] acc;
        a   = 64'(lo ^ SIGN_FLIP);
        b   = 64'(hi ^ SIGN_FLIP);
        f   = 64'(frac);
        acc = a * ((64'd1 << FB) - f) + b * f;
        acc = (acc + (64'd1 << (FB - 1))) >> FB;
        return acc[SB-1:0] ^ SIGN_FLIP;
    endfunction

    // Advance the model by one input sample and return its result.
    function automatic lir_result_t resample_step(logic [SB-1:0] smp, logic last);
        lir_result_t         r;
        logic [POS_BITS-1:0] stride;
        logic [63:0]         sum;
        stride      = (step_ratio < RATIO_UNITY) ? POS_BITS'(RATIO_UNITY)
                                                 : POS_BITS'(step_ratio);
        r           = '0;
        r.frame_end = last;
        if (frm_index == '0)
        begin
            // output 0 of the frame: always zero
            r.produced = 1'b1;
            frm_pos    = stride;
        end
        else if ((frm_pos >> FB) < POS_BITS'(frm_index))
        begin
            // both neighbors of the next position are now known
            r.value    = interp_q15(frm_prev, smp, frm_pos[FB-1:0]);
            r.produced = 1'b1;
            sum        = 64'(frm_pos) + 64'(stride);
            frm_pos    = (sum > POS_LIMIT) ? POS_LIMIT[POS_BITS-1:0] : sum[POS_BITS-1:0];
        end
        if (r.produced && frm_count != IDX_LIMIT)
            frm_count = frm_count + 1'b1;
        r.count  = frm_count;
        frm_prev = smp;
        if (frm_index != IDX_LIMIT)
            frm_index = frm_index + 1'b1;
        if (last)
        begin
            frm_index = '0;
            frm_pos   = '0;
            frm_prev  = '0;
            frm_count = '0;
        end
        return r;
    endfunction

    // Mostly full-range noise, with extremes and near-zero values mixed in
    // so that saturation corners and rounding ties show up.
    function automatic logic [SB-1:0] draw_sample();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return ($urandom_range(0, 1) != 0) ? SIGN_FLIP : ~SIGN_FLIP;
        else if (sel == 1)
            return SB'($urandom_range(0, 4) - 2);
        return SB'($urandom());
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sample source: one transaction per call. Valid rises at a falling
    // edge after an optional gap; the transaction lands at the rising edge
    // where ready is seen high, and the model is stepped right there.
    // ------------------------------------------------------------------------
    task automatic send_sample(logic [SB-1:0] smp, logic last, logic typed,
                               lir_result_t typed_want);
        int          gap;
        lir_result_t predicted;
        gap = src_gaps_on ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        smp_ch.valid         <= 1'b1;
        smp_ch.in_sample     <= smp;
        smp_ch.last_in_frame <= last;
        @(posedge clk);
        while (!smp_ch.ready) @(posedge clk);
        predicted = resample_step(smp, last);
        expected_results.insert(expected_results.size(), typed ? typed_want : predicted);
    endtask

    // Ratio write: the sample channel is quiet and every result is home
    // before the register transaction goes out.
    task automatic write_ratio(logic [RATIO_BITS-1:0] value);
        @(negedge clk);
        smp_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.rate_ratio <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        step_ratio = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: ready drops for a random number of cycles per result,
    // then each accepted transaction is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_result();
        lir_result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: value=%0d produced=%0b end=%0b count=%0d",
                         res_ch.out_sample, res_ch.out_valid, res_ch.frame_end,
                         res_ch.produced_count);
            return;
        end
        want = expected_results.pop_front();
        if (res_ch.out_sample !== want.value || res_ch.out_valid !== want.produced ||
            res_ch.frame_end !== want.frame_end || res_ch.produced_count !== want.count)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: exp %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
                         want.value, want.produced, want.frame_end, want.count,
                         res_ch.out_sample, res_ch.out_valid, res_ch.frame_end,
                         res_ch.produced_count);
        end
    endtask

    initial
    begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        forever
        begin
            stall = snk_stalls_on ? $urandom_range(0, 9) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            check_result();
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: idle_cycles is cleared by any transaction on any channel;
    // a run in which it reaches WDOG_LIMIT is hung.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed table first, then random phases. Each phase picks
    // a ratio class and whether gaps/stalls are on, then sends whole frames.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int            items_sent;
        int            phase_items;
        int            in_phase;
        int            flen;
        ratio_kind_t   kind;
        logic [RATIO_BITS-1:0] ratio;

        items_sent           = 0;
        rst_n                = 1'b0;
        smp_ch.valid         = 1'b0;
        smp_ch.in_sample     = '0;
        smp_ch.last_in_frame = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.rate_ratio    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIR_TAB[i])
        begin
            if (DIR_TAB[i].kind == ROW_WRITE)
                write_ratio(DIR_TAB[i].ratio);
            else
                send_sample(DIR_TAB[i].smp, DIR_TAB[i].last, DIR_TAB[i].typed,
                            DIR_TAB[i].want);
        end

        while (items_sent < RANDOM_ITEMS)
        begin
            kind = ratio_kind_t'($urandom_range(0, 6));
            case (kind)
                RATIO_ZERO:      ratio = '0;
                RATIO_BELOW_ONE: ratio = RATIO_BITS'($urandom_range(1, 24'h00FFFF));
                RATIO_ONE:       ratio = RATIO_UNITY;
                RATIO_MAX:       ratio = '1;
                RATIO_SMALL:     ratio = RATIO_BITS'($urandom_range(24'h010000, 24'h040000));
                RATIO_HALF_STEP: ratio = {8'($urandom_range(1, 3)), 16'h8000};
                default:         ratio = RATIO_BITS'($urandom());
            endcase
            write_ratio(ratio);

            // roughly one phase in four runs flat out on each side
            src_gaps_on   = ($urandom_range(0, 3) != 0);
            snk_stalls_on = ($urandom_range(0, 3) != 0);
            phase_items   = $urandom_range(40, 150);
            in_phase      = 0;
            while (in_phase < phase_items)
            begin
                // long frames only where the ratio is big enough to need them
                if (ratio >= 24'h100000 && $urandom_range(0, 3) == 0)
                    flen = $urandom_range(20, 300);
                else
                    flen = $urandom_range(1, 24);
                for (int k = 0; k < flen; k++)
                    send_sample(draw_sample(), k == flen - 1, 1'b0, NO_RES);
                in_phase += flen;
            end
            items_sent += in_phase;
        end

        @(negedge clk);
        smp_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
